FILE: design/tps_pkg.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler package
// Shared widths, command and register codes, and the request and response
// structures of the bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

    localparam int DVD_W     = 58;
    localparam int DVS_W     = 20;
    localparam int MUL_W     = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int MUL_CNT_W = $clog2(MUL_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_PASSES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INCH_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_START   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd6;

    localparam logic [DVS_W-1:0] DIV_MILLI  = 20'd1000;
    localparam logic [MUL_W-1:0] MUL_MILLI  = 16'd1000;
    localparam logic [DVD_W-1:0] K_INCH_UM  = 58'd25400;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] mcand;
        logic [MUL_W-1:0] mult;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

FILE: design/tps_div.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_div import tps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_quot;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {r_rem, r_quot[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W - 1);
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], fits};
            r_rem  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/tps_mul.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler multiplier
// Shift-and-add multiplier that takes one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_mul import tps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_acc;
    logic [DVD_W-1:0]     r_mcand;
    logic [MUL_W-1:0]     r_mult;

    logic [DVD_W-1:0] n_acc;

    assign n_acc = {r_acc[DVD_W-2:0], 1'b0} + (r_mult[MUL_W-1] ? r_mcand : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_W - 1);
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc   <= '0;
            r_mcand <= i_req.mcand;
            r_mult  <= i_req.mult;
        end else if (r_busy) begin
            r_acc  <= n_acc;
            r_mult <= {r_mult[MUL_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

`default_nettype wire

FILE: design/thread_pass_scheduler_core.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler core
// A start request passes from the load state to the done state; in inch mode,
// two divisions on the bit-serial divider run in turn between them, the second
// skipped when the first quotient is zero. A next-pass request runs up to four
// divisions and two multiplications, one after another; at the maximum depth the
// passes-left division is skipped. A zero pitch skips the angle work. One request
// is held at a time; the next is accepted the cycle after the result is loaded.
// Synchronous active-low reset restores the register defaults and clears the job.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_pass_scheduler_core import tps_pkg::*; #(
    parameter int unsigned ANGLE_COUNTS = 3000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic signed [23:0]    i_tool_position,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_pass_ok,
    output logic [15:0]           o_depth_now,
    output logic [15:0]           o_step_cut,
    output logic signed [16:0]    o_passes_left,
    output logic [11:0]           o_entry_angle,
    output logic [19:0]           o_pitch,
    output logic                  o_pitch_error
);

    localparam logic [MUL_W-1:0] ANGLE_K = MUL_W'(ANGLE_COUNTS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_INCH_A = 4'd2;
    localparam logic [3:0] ST_INCH_B = 4'd3;
    localparam logic [3:0] ST_PREP   = 4'd4;
    localparam logic [3:0] ST_LEFT   = 4'd5;
    localparam logic [3:0] ST_ANG    = 4'd6;
    localparam logic [3:0] ST_MUL_A  = 4'd7;
    localparam logic [3:0] ST_DIV_A  = 4'd8;
    localparam logic [3:0] ST_MUL_B  = 4'd9;
    localparam logic [3:0] ST_DIV_B  = 4'd10;
    localparam logic [3:0] ST_SUM    = 4'd11;
    localparam logic [3:0] ST_MOD    = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0]  r_state;

    logic [15:0] r_max_depth;
    logic [15:0] r_depth_step;
    logic [7:0]  r_spring_passes;
    logic [19:0] r_thread_size;
    logic        r_inch_mode;
    logic [23:0] r_entry_start;
    logic [11:0] r_start_angle;

    logic [19:0] r_pitch;
    logic [15:0] r_depth;
    logic [7:0]  r_spring;
    logic [31:0] r_rs;

    logic             r_cmd;
    logic [23:0]      r_pos;
    logic [15:0]      r_step;
    logic [16:0]      r_nd;
    logic [DVD_W-1:0] r_work;
    logic             r_neg;

    logic        r_res_ok;
    logic [15:0] r_res_cut;
    logic [16:0] r_res_left;
    logic [11:0] r_res_ang;

    logic        r_out_valid;
    logic        r_out_ok;
    logic [15:0] r_out_depth;
    logic [15:0] r_out_cut;
    logic [16:0] r_out_left;
    logic [11:0] r_out_ang;
    logic [19:0] r_out_pitch;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic [15:0]      step_eff;
    logic [16:0]      n_nd;
    logic [31:0]      n_rs;
    logic             reach;
    logic [16:0]      over;
    logic [15:0]      room;
    logic [15:0]      cut_clamp;
    logic [33:0]      d_full;
    logic [33:0]      d_mag;
    logic [DVD_W-1:0] ssa_ext;
    logic             q_ge_ssa;
    logic [DVD_W-1:0] sum_mag;
    logic             sum_neg;
    logic [15:0]      rem16;
    logic [15:0]      ang16;

    tps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tps_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign step_eff  = (r_depth_step == '0) ? 16'd1 : r_depth_step;
    assign n_nd      = {1'b0, r_depth} + {1'b0, step_eff};
    assign n_rs      = r_rs - {17'd0, step_eff[15:1]};
    assign reach     = (r_nd >= {1'b0, r_max_depth});
    assign over      = r_nd - {1'b0, r_max_depth};
    assign room      = r_max_depth - r_nd[15:0];
    assign cut_clamp = (r_max_depth >= r_depth) ? (r_max_depth - r_depth) : 16'd0;
    assign d_full    = {{10{r_pos[23]}}, r_pos} - {{2{r_rs[31]}}, r_rs};
    assign d_mag     = d_full[33] ? (34'd0 - d_full) : d_full;
    assign ssa_ext   = {{(DVD_W-12){1'b0}}, r_start_angle};
    assign q_ge_ssa  = (r_work >= ssa_ext);
    assign rem16     = div_rsp.rem[15:0];
    assign ang16     = (r_neg && (rem16 != '0)) ? (ANGLE_K - rem16) : rem16;

    always_comb begin
        if (!r_neg) begin
            sum_mag = r_work + ssa_ext;
            sum_neg = 1'b0;
        end else if (q_ge_ssa) begin
            sum_mag = r_work - ssa_ext;
            sum_neg = 1'b1;
        end else begin
            sum_mag = ssa_ext - r_work;
            sum_neg = 1'b0;
        end
    end

    always_comb begin
        div_req = '0;
        mul_req = '0;
        unique case (r_state)
            ST_LOAD: begin
                if ((r_cmd == CMD_START) && r_inch_mode) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(DVD_W-20){1'b0}}, r_thread_size};
                    div_req.divisor  = DIV_MILLI;
                end
            end
            ST_INCH_A: begin
                if (div_rsp.done && (div_rsp.quot != '0)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = K_INCH_UM;
                    div_req.divisor  = div_rsp.quot[DVS_W-1:0];
                end
            end
            ST_PREP: begin
                if (!reach) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(DVD_W-16){1'b0}}, room};
                    div_req.divisor  = {{(DVS_W-16){1'b0}}, r_step};
                end
            end
            ST_ANG: begin
                if (r_pitch != '0) begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = r_work;
                    mul_req.mult  = MUL_MILLI;
                end
            end
            ST_MUL_A: begin
                if (mul_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.prod;
                    div_req.divisor  = r_pitch;
                end
            end
            ST_DIV_A: begin
                if (div_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = div_rsp.quot;
                    mul_req.mult  = ANGLE_K;
                end
            end
            ST_MUL_B: begin
                if (mul_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.prod;
                    div_req.divisor  = DIV_MILLI;
                end
            end
            ST_SUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_mag;
                div_req.divisor  = {{(DVS_W-MUL_W){1'b0}}, ANGLE_K};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_max_depth     <= 16'd0;
            r_depth_step    <= 16'd1;
            r_spring_passes <= 8'd0;
            r_thread_size   <= 20'd1000;
            r_inch_mode     <= 1'b0;
            r_entry_start   <= 24'd0;
            r_start_angle   <= 12'd0;
            r_pitch         <= '0;
            r_depth         <= '0;
            r_spring        <= '0;
            r_rs            <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_DEPTH:     r_max_depth     <= i_cfg_data[15:0];
                    CFG_DEPTH_STEP:    r_depth_step    <= i_cfg_data[15:0];
                    CFG_SPRING_PASSES: r_spring_passes <= i_cfg_data[7:0];
                    CFG_THREAD_SIZE:   r_thread_size   <= i_cfg_data[19:0];
                    CFG_INCH_MODE:     r_inch_mode     <= i_cfg_data[0];
                    CFG_ENTRY_START:   r_entry_start   <= i_cfg_data[23:0];
                    CFG_START_ANGLE:   r_start_angle   <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_pos   <= i_tool_position;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (r_cmd == CMD_START) begin
                        r_depth    <= '0;
                        r_spring   <= '0;
                        r_rs       <= {{8{r_entry_start[23]}}, r_entry_start};
                        r_res_ok   <= 1'b0;
                        r_res_cut  <= '0;
                        r_res_left <= '0;
                        r_res_ang  <= '0;
                        if (r_inch_mode) begin
                            r_state <= ST_INCH_A;
                        end else begin
                            r_pitch <= r_thread_size;
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_step  <= step_eff;
                        r_nd    <= n_nd;
                        r_rs    <= n_rs;
                        r_state <= ST_PREP;
                    end
                end
                ST_INCH_A: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot == '0) begin
                            r_pitch <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_INCH_B;
                        end
                    end
                end
                ST_INCH_B: begin
                    if (div_rsp.done) begin
                        r_pitch <= div_rsp.quot[19:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_PREP: begin
                    r_neg  <= d_full[33];
                    r_work <= {{(DVD_W-34){1'b0}}, d_mag};
                    if (reach) begin
                        r_depth    <= r_max_depth;
                        r_res_cut  <= cut_clamp;
                        r_res_left <= (over >= {1'b0, r_step}) ? 17'h1FFFF : 17'd0;
                        if (r_spring < r_spring_passes) begin
                            r_spring <= r_spring + 8'd1;
                            r_res_ok <= 1'b1;
                        end else begin
                            r_res_ok <= 1'b0;
                        end
                        r_state <= ST_ANG;
                    end else begin
                        r_depth   <= r_nd[15:0];
                        r_res_cut <= r_step;
                        r_res_ok  <= 1'b1;
                        r_state   <= ST_LEFT;
                    end
                end
                ST_LEFT: begin
                    if (div_rsp.done) begin
                        r_res_left <= {1'b0, div_rsp.quot[15:0]};
                        r_state    <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    if (r_pitch == '0) begin
                        r_res_ang <= '0;
                        r_state   <= ST_DONE;
                    end else begin
                        r_state <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_DIV_A;
                    end
                end
                ST_DIV_A: begin
                    if (div_rsp.done) begin
                        r_state <= ST_MUL_B;
                    end
                end
                ST_MUL_B: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_DIV_B;
                    end
                end
                ST_DIV_B: begin
                    if (div_rsp.done) begin
                        r_work  <= div_rsp.quot;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_neg   <= sum_neg;
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (div_rsp.done) begin
                        r_res_ang <= ang16[11:0];
                        r_state   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_res_ok;
                        r_out_depth <= r_depth;
                        r_out_cut   <= r_res_cut;
                        r_out_left  <= r_res_left;
                        r_out_ang   <= r_res_ang;
                        r_out_pitch <= r_pitch;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pass_ok     = r_out_ok;
    assign o_depth_now   = r_out_depth;
    assign o_step_cut    = r_out_cut;
    assign o_passes_left = r_out_left;
    assign o_entry_angle = r_out_ang;
    assign o_pitch       = r_out_pitch;
    assign o_pitch_error = (r_out_pitch == '0);

endmodule

`default_nettype wire

FILE: design/tps_checker.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler checker
// Port-level checks on the scheduler, attached to the core by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_pass_ok,
    input logic [15:0]        o_depth_now,
    input logic [15:0]        o_step_cut,
    input logic signed [16:0] o_passes_left,
    input logic [11:0]        o_entry_angle,
    input logic [19:0]        o_pitch,
    input logic               o_pitch_error
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_depth_now)
            && $stable(o_passes_left) && $stable(o_entry_angle) && $stable(o_pitch))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in progress");

    a_pitch_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_error == (o_pitch == 20'd0)))
        else $error("pitch error flag disagrees with pitch");

    a_cut_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_cut <= o_depth_now))
        else $error("step cut exceeds depth reached");

    a_left_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_passes_left[16] && (o_passes_left != 17'd0) |-> o_pass_ok)
        else $error("passes remain but no pass is allowed");

endmodule

bind thread_pass_scheduler_core tps_checker u_tps_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Thread pass scheduler testbench
// Drives start and next-pass requests through the valid/stall handshake,
// with random gaps on the request side and random stalls on the result side.
// A predictor keeps its own copy of the job state and the settings and
// works out the result of every accepted request. Each result is compared
// field by field with the oldest outstanding prediction. Directed jobs cover
// reset defaults, metric and inch pitches, field extremes and the corner
// cases; random jobs with random settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import tps_pkg::*;

    localparam longint ANGLE_N     = 3000;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     RANDOM_REQS = 600;

    typedef struct packed {
        logic               pass_ok;
        logic [15:0]        depth_now;
        logic [15:0]        step_cut;
        logic signed [16:0] passes_left;
        logic [11:0]        entry_angle;
        logic [19:0]        pitch;
        logic               pitch_error;
    } t_pass_plan;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic signed [23:0]    i_tool_position;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_pass_ok;
    logic [15:0]           o_depth_now;
    logic [15:0]           o_step_cut;
    logic signed [16:0]    o_passes_left;
    logic [11:0]           o_entry_angle;
    logic [19:0]           o_pitch;
    logic                  o_pitch_error;

    // Settings as the block holds them.
    logic [15:0]        set_max_depth   = 16'd0;
    logic [15:0]        set_depth_step  = 16'd1;
    logic [7:0]         set_spring      = 8'd0;
    logic [19:0]        set_thread_size = 20'd1000;
    logic               set_inch_mode   = 1'b0;
    logic signed [23:0] set_entry_start = 24'sd0;
    logic [11:0]        set_start_angle = 12'd0;

    // Job state of the predictor.
    logic [19:0] job_pitch   = 20'd0;
    logic [15:0] depth_done  = 16'd0;
    logic [7:0]  spring_used = 8'd0;
    logic [31:0] entry_run   = 32'd0;

    t_pass_plan plans_due[$];
    int         failures;
    int         cycles;
    logic       idle_en;
    int         stall_run;

    thread_pass_scheduler_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_tool_position (i_tool_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pass_ok       (o_pass_ok),
        .o_depth_now     (o_depth_now),
        .o_step_cut      (o_step_cut),
        .o_passes_left   (o_passes_left),
        .o_entry_angle   (o_entry_angle),
        .o_pitch         (o_pitch),
        .o_pitch_error   (o_pitch_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MAX_DEPTH:     set_max_depth   = data[15:0];
            CFG_DEPTH_STEP:    set_depth_step  = data[15:0];
            CFG_SPRING_PASSES: set_spring      = data[7:0];
            CFG_THREAD_SIZE:   set_thread_size = data[19:0];
            CFG_INCH_MODE:     set_inch_mode   = data[0];
            CFG_ENTRY_START:   set_entry_start = data[23:0];
            CFG_START_ANGLE:   set_start_angle = data[11:0];
            default: ;
        endcase
    endfunction

    function automatic t_pass_plan plan_pass(input logic cmd, input logic signed [23:0] pos);
        t_pass_plan  r;
        longint      stp;
        longint      maxd;
        longint      nd;
        longint      cut;
        longint      rem;
        longint      pos_diff;
        longint      ang;
        int unsigned tpi;
        r = '0;
        if (cmd == CMD_START) begin
            if (set_inch_mode) begin
                tpi = set_thread_size / 1000;
                job_pitch = (tpi != 0) ? 20'(25400 / tpi) : 20'd0;
            end else begin
                job_pitch = set_thread_size;
            end
            depth_done  = 16'd0;
            spring_used = 8'd0;
            entry_run   = 32'(set_entry_start);
        end else begin
            stp  = (set_depth_step != 16'd0) ? longint'(set_depth_step) : 64'sd1;
            maxd = longint'(set_max_depth);
            nd   = longint'(depth_done) + stp;
            cut  = stp;
            entry_run = entry_run - 32'(stp / 2);
            rem = (maxd - nd) / stp;
            if (rem < -1) rem = -1;
            if (nd >= maxd) begin
                cut = cut - (nd - maxd);
                if (cut < 0) cut = 0;
                nd = maxd;
                if (spring_used < set_spring) begin
                    spring_used = spring_used + 8'd1;
                    r.pass_ok = 1'b1;
                end
            end else begin
                r.pass_ok = 1'b1;
            end
            depth_done    = 16'(nd);
            r.step_cut    = 16'(cut);
            r.passes_left = 17'(rem);
            if (job_pitch != 20'd0) begin
                pos_diff = longint'(pos) - longint'(signed'(entry_run));
                ang  = ((pos_diff * 1000) / longint'(job_pitch)) * ANGLE_N / 1000;
                ang  = (ang + longint'(set_start_angle)) % ANGLE_N;
                if (ang < 0) ang = ang + ANGLE_N;
                r.entry_angle = 12'(ang);
            end
        end
        r.depth_now   = depth_done;
        r.pitch       = job_pitch;
        r.pitch_error = (job_pitch == 20'd0);
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pass_plan want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (plans_due.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = plans_due.pop_front();
                if (o_pass_ok !== want.pass_ok) begin
                    $error("pass_ok: expected %0d, got %0d", want.pass_ok, o_pass_ok);
                    failures++;
                end
                if (o_depth_now !== want.depth_now) begin
                    $error("depth_now: expected %0d, got %0d", want.depth_now, o_depth_now);
                    failures++;
                end
                if (o_step_cut !== want.step_cut) begin
                    $error("step_cut: expected %0d, got %0d", want.step_cut, o_step_cut);
                    failures++;
                end
                if (o_passes_left !== want.passes_left) begin
                    $error("passes_left: expected %0d, got %0d",
                           want.passes_left, o_passes_left);
                    failures++;
                end
                if (o_entry_angle !== want.entry_angle) begin
                    $error("entry_angle: expected %0d, got %0d",
                           want.entry_angle, o_entry_angle);
                    failures++;
                end
                if (o_pitch !== want.pitch) begin
                    $error("pitch: expected %0d, got %0d", want.pitch, o_pitch);
                    failures++;
                end
                if (o_pitch_error !== want.pitch_error) begin
                    $error("pitch_error: expected %0d, got %0d",
                           want.pitch_error, o_pitch_error);
                    failures++;
                end
            end
        end
    end

    // Result-side stalls alternate with stretches of free flow.
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (idle_en && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= rand_gap();
        end else begin
            i_out_stall <= 1'b0;
            stall_run   <= $urandom_range(0, 20);
        end
    end

    task automatic send_request(input logic cmd, input logic signed [23:0] pos);
        int n;
        n = idle_en ? rand_gap() : 0;
        @(negedge i_clk);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_tool_position = pos;
        do @(posedge i_clk); while (o_in_stall);
        plans_due.push_back(plan_pass(cmd, pos));
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (plans_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(value);
        @(posedge i_clk);
        apply_setting(idx, CFG_DATA_W'(value));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_reset_defaults();
        // A next-pass request before any job has no pitch to work with.
        send_request(CMD_NEXT, 24'sd1234);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, 24'sd500);
        settle();
    endtask

    task automatic test_metric_job();
        cfg_write(CFG_MAX_DEPTH, 300);
        cfg_write(CFG_DEPTH_STEP, 70);
        cfg_write(CFG_SPRING_PASSES, 2);
        cfg_write(CFG_THREAD_SIZE, 1500);
        cfg_write(CFG_INCH_MODE, 0);
        cfg_write(CFG_ENTRY_START, 24'(-1234));
        cfg_write(CFG_START_ANGLE, 2999);
        send_request(CMD_START, 24'sd0);
        repeat (7) send_request(CMD_NEXT, 24'(-1000 - $urandom_range(0, 3000)));
        settle();
    endtask

    task automatic test_inch_pitch();
        cfg_write(CFG_INCH_MODE, 1);
        // Below one thread per inch the divisor is zero.
        cfg_write(CFG_THREAD_SIZE, 999);
        send_request(CMD_START, 24'sd0);
        settle();
        cfg_write(CFG_THREAD_SIZE, 1000);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, 24'sd20000);
        settle();
        cfg_write(CFG_THREAD_SIZE, 20'hFFFFF);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, -24'sd777);
        settle();
    endtask

    task automatic test_field_extremes();
        cfg_write(CFG_INCH_MODE, 0);
        cfg_write(CFG_MAX_DEPTH, 16'hFFFF);
        cfg_write(CFG_DEPTH_STEP, 16'hFFFF);
        cfg_write(CFG_SPRING_PASSES, 255);
        cfg_write(CFG_THREAD_SIZE, 20'hFFFFF);
        cfg_write(CFG_ENTRY_START, 24'h7FFFFF);
        send_request(CMD_START, 24'sh7FFFFF);
        send_request(CMD_NEXT, 24'sh800000);
        send_request(CMD_NEXT, 24'sh7FFFFF);
        settle();
        // A zero depth step is taken as one.
        cfg_write(CFG_DEPTH_STEP, 0);
        cfg_write(CFG_THREAD_SIZE, 1);
        cfg_write(CFG_ENTRY_START, 24'h800000);
        cfg_write(CFG_START_ANGLE, 0);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, 24'sh7FFFFF);
        settle();
        // A zero metric size gives a zero pitch.
        cfg_write(CFG_THREAD_SIZE, 0);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, 24'sd100);
        settle();
        // Lowering the maximum below the depth already cut.
        cfg_write(CFG_THREAD_SIZE, 2000);
        cfg_write(CFG_MAX_DEPTH, 1000);
        cfg_write(CFG_DEPTH_STEP, 400);
        cfg_write(CFG_SPRING_PASSES, 0);
        send_request(CMD_START, 24'sd0);
        send_request(CMD_NEXT, 24'sd300);
        send_request(CMD_NEXT, 24'sd600);
        settle();
        cfg_write(CFG_MAX_DEPTH, 100);
        send_request(CMD_NEXT, 24'sd900);
        settle();
    endtask

    task automatic test_random_jobs();
        int sent;
        int phase_sent;
        int k;
        logic inch;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            settle();
            idle_en = ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 9);
            cfg_write(CFG_MAX_DEPTH, (k == 0) ? 0 : (k == 1) ? 16'hFFFF
                                     : $urandom_range(0, 3000));
            k = $urandom_range(0, 9);
            cfg_write(CFG_DEPTH_STEP, (k == 0) ? 16'hFFFF : (k == 1) ? 1
                                      : $urandom_range(1, 600));
            k = $urandom_range(0, 9);
            cfg_write(CFG_SPRING_PASSES, (k == 0) ? 255 : $urandom_range(0, 4));
            inch = ($urandom_range(0, 2) == 0);
            cfg_write(CFG_INCH_MODE, inch);
            k = $urandom_range(0, 9);
            if (inch) begin
                cfg_write(CFG_THREAD_SIZE, (k == 0) ? $urandom_range(0, 999)
                                         : (k == 1) ? $urandom_range(0, 20'hFFFFF)
                                         : $urandom_range(1000, 80000));
            end else begin
                cfg_write(CFG_THREAD_SIZE, (k == 0) ? 20'hFFFFF
                                         : (k == 1) ? $urandom_range(1, 20'hFFFFF)
                                         : $urandom_range(100, 8000));
            end
            cfg_write(CFG_ENTRY_START, $urandom);
            k = $urandom_range(0, 9);
            cfg_write(CFG_START_ANGLE, (k == 0) ? 2999 : $urandom_range(0, 2999));
            phase_sent = 0;
            while (phase_sent < 50) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_request(CMD_START, 24'($urandom));
                    k = $urandom_range(1, 30);
                    phase_sent += k + 1;
                    repeat (k) begin
                        if ($urandom_range(0, 1) == 0)
                            send_request(CMD_NEXT, 24'($urandom));
                        else
                            send_request(CMD_NEXT,
                                24'(set_entry_start + $urandom_range(0, 4000) - 2000));
                    end
                end else begin
                    send_request(1'($urandom), 24'($urandom));
                    phase_sent++;
                end
            end
            sent += phase_sent;
        end
        settle();
    endtask

    initial begin
        failures        = 0;
        cycles          = 0;
        idle_en         = 1'b1;
        stall_run       = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_MAX_DEPTH;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_command       = CMD_START;
        i_tool_position = '0;
        i_out_stall     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_metric_job();
        test_inch_pitch();
        test_field_extremes();
        test_random_jobs();

        repeat (400) @(posedge i_clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: thread_pass_scheduler_core.f
design/tps_pkg.sv
design/tps_div.sv
design/tps_mul.sv
design/thread_pass_scheduler_core.sv
design/tps_checker.sv
tb/sv/tb.sv
